>>> design/ttsf_pkg.sv
// ----------------------------------------------------------------------------
// ttsf_pkg: shared types and constants of the text to segment frame writer
// Holds the transaction payload types, mode and driver register codes, the
// segment table and the fixed init frame sequence.
// ----------------------------------------------------------------------------
package ttsf_pkg;

    // Input item modes.
    localparam logic [1:0] MODE_CHAR   = 2'd0;
    localparam logic [1:0] MODE_BRIGHT = 2'd1;
    localparam logic [1:0] MODE_INIT   = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // Display driver register addresses.
    localparam logic [3:0] ADDR_DECODE = 4'h9;
    localparam logic [3:0] ADDR_BRIGHT = 4'hA;
    localparam logic [3:0] ADDR_SCAN   = 4'hB;
    localparam logic [3:0] ADDR_POWER  = 4'hC;
    localparam logic [3:0] ADDR_TEST   = 4'hF;

    localparam logic [7:0] POINT_BIT  = 8'h80;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [3:0] MAX_LEVEL  = 4'hF;
    localparam logic [2:0] INIT_COUNT = 3'd5;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0] mode;
        logic       start_of_message;
        logic [7:0] value;
    } in_item_t;

    // Result transaction payload.
    typedef struct packed {
        logic [3:0] frame_address;
        logic [7:0] frame_data;
        logic       last_of_run;
    } out_item_t;

    // Message and brightness state kept between items.
    typedef struct packed {
        logic [3:0] digit_position;
        logic [7:0] held_code;
        logic       held_valid;
        logic       dot_consumed;
        logic       message_done;
        logic [3:0] last_brightness;
    } msg_state_t;

    // Frames caused by one item: up to two explicit frames or the init run.
    typedef struct packed {
        logic       init_seq;
        logic [2:0] count;
        logic [3:0] slot0_address;
        logic [7:0] slot0_data;
        logic [3:0] slot1_address;
        logic [7:0] slot1_data;
    } burst_t;

    // Segment codes for character codes 0..127; code 128 and above are blank.
    localparam logic [7:0] SEG_TABLE [0:127] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'hE5, 8'hE5, 8'hE5, 8'hE5, 8'hE5, 8'hE5, 8'hE5,
        8'hE5, 8'hE5, 8'hE5, 8'hE5, 8'hE5, 8'h01, 8'hE5, 8'hE5,
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
        8'h7F, 8'h7B, 8'hE5, 8'hE5, 8'hE5, 8'hE5, 8'hE5, 8'hE5,
        8'hE5, 8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47, 8'h5F,
        8'h37, 8'h30, 8'h3C, 8'h87, 8'h0E, 8'hE5, 8'h76, 8'h7E,
        8'h67, 8'hFE, 8'h66, 8'h5B, 8'h0F, 8'h3E, 8'h3E, 8'hE5,
        8'h37, 8'h33, 8'h6D, 8'hE5, 8'hE5, 8'hE5, 8'hE5, 8'hE5,
        8'hE5, 8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47, 8'h5F,
        8'h17, 8'h30, 8'h3C, 8'h87, 8'h0E, 8'hE5, 8'h15, 8'h1D,
        8'h67, 8'h73, 8'h05, 8'h5B, 8'h0F, 8'h1C, 8'h1C, 8'hD3,
        8'h37, 8'h33, 8'h6D, 8'hE5, 8'hE5, 8'hE5, 8'hE5, 8'hE5
    };

    // Segment code of a character.
    function automatic logic [7:0] seg_code(input logic [7:0] ch);
        seg_code = ch[7] ? 8'h00 : SEG_TABLE[ch[6:0]];
    endfunction

    // Address and data of one frame of the driver setup sequence.
    function automatic logic [11:0] init_frame(input logic [2:0] idx);
        logic [11:0] f;
        unique case (idx)
            3'd0:    f = {ADDR_TEST,   8'h00};
            3'd1:    f = {ADDR_SCAN,   8'h07};
            3'd2:    f = {ADDR_DECODE, 8'h00};
            3'd3:    f = {ADDR_BRIGHT, 8'h0A};
            3'd4:    f = {ADDR_POWER,  8'h01};
            default: f = {ADDR_POWER,  8'h01};
        endcase
        init_frame = f;
    endfunction

endpackage

>>> design/text_to_segment_frame_writer.sv
// ----------------------------------------------------------------------------
// text_to_segment_frame_writer: text characters to display driver frames
// Maps characters to segment codes, folds periods into the previous digit,
// and serializes the frames of each item onto the result channel.
// ----------------------------------------------------------------------------
// The first frame of an item is offered in the cycle after acceptance.
// Throughput: while m_ready is high, one item per cycle if each causes at most one frame;
// an item with n frames (n up to 5) occupies the frame buffer for n result
// transactions, so the result channel's accept rate sets the item rate.
// Reset: synchronous active-low aresetn clears message state, the last
// brightness level and any frames not yet delivered.
module text_to_segment_frame_writer #(
    parameter int DIGITS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ttsf_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ttsf_pkg::out_item_t m_data
);
    import ttsf_pkg::*;

    msg_state_t state_reg;
    msg_state_t state_next;
    burst_t     burst_new;

    logic       init_reg;
    logic [2:0] count_reg;
    logic [2:0] idx_reg;
    logic [3:0] slot0_address_reg;
    logic [7:0] slot0_data_reg;
    logic [3:0] slot1_address_reg;
    logic [7:0] slot1_data_reg;

    logic        s_accept;
    logic        m_accept;
    logic        last_frame;
    logic [11:0] init_f;

    // Per-item decode.
    ttsf_item_logic #(
        .DIGITS(DIGITS)
    ) u_item_logic (
        .item      (s_data),
        .state_cur (state_reg),
        .state_next(state_next),
        .burst     (burst_new)
    );

    // Handshakes: a new item is taken when the buffer is empty or empties this cycle.
    assign m_valid    = (count_reg != 3'd0);
    assign last_frame = (idx_reg == count_reg - 3'd1);
    assign m_accept   = m_valid && m_ready;
    assign s_ready    = !m_valid || (m_ready && last_frame);
    assign s_accept   = s_valid && s_ready;

    // Message state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // Frame buffer control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 3'd0;
            idx_reg   <= 3'd0;
            init_reg  <= 1'b0;
        end else if (s_accept) begin
            count_reg <= burst_new.count;
            idx_reg   <= 3'd0;
            init_reg  <= burst_new.init_seq;
        end else if (m_accept) begin
            if (last_frame) begin
                count_reg <= 3'd0;
                idx_reg   <= 3'd0;
            end else begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    // Frame buffer payload.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            slot0_address_reg <= burst_new.slot0_address;
            slot0_data_reg    <= burst_new.slot0_data;
            slot1_address_reg <= burst_new.slot1_address;
            slot1_data_reg    <= burst_new.slot1_data;
        end
    end

    // Output frame selection.
    assign init_f = init_frame(idx_reg);
    always_comb begin
        if (init_reg) begin
            m_data.frame_address = init_f[11:8];
            m_data.frame_data    = init_f[7:0];
        end else if (idx_reg == 3'd0) begin
            m_data.frame_address = slot0_address_reg;
            m_data.frame_data    = slot0_data_reg;
        end else begin
            m_data.frame_address = slot1_address_reg;
            m_data.frame_data    = slot1_data_reg;
        end
        m_data.last_of_run = last_frame;
    end

    // The frame index stays inside the buffered run.
    a_idx_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (idx_reg < count_reg))
        else $error("frame index beyond buffered run");

    // Only the init run holds more than two frames.
    a_run_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !init_reg) |-> (count_reg <= 3'd2))
        else $error("character or brightness run longer than two frames");

    // An accepted init item loads a full five-frame run.
    a_init_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_data.mode == MODE_INIT) |=>
            (m_valid && init_reg && count_reg == INIT_COUNT && idx_reg == 3'd0))
        else $error("init item did not load the setup run");

    // A finished message holds no digit.
    a_done_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.message_done |-> !state_reg.held_valid)
        else $error("digit held after message end");

endmodule

>>> design/ttsf_item_logic.sv
// ----------------------------------------------------------------------------
// ttsf_item_logic: per-item decode and state update
// Works out, for one input item, the next message state and the frames that
// the item causes.
// ----------------------------------------------------------------------------
module ttsf_item_logic #(
    parameter int DIGITS = 8
) (
    input  ttsf_pkg::in_item_t   item,
    input  ttsf_pkg::msg_state_t state_cur,
    output ttsf_pkg::msg_state_t state_next,
    output ttsf_pkg::burst_t     burst
);
    import ttsf_pkg::*;

    msg_state_t base;
    logic [7:0] code;
    logic [3:0] pos_inc;
    logic       flush;
    logic [3:0] level;

    // Start of a new message clears the message state before the character.
    always_comb begin
        base = state_cur;
        if (item.start_of_message) begin
            base.digit_position = 4'd0;
            base.held_code      = 8'h00;
            base.held_valid     = 1'b0;
            base.dot_consumed   = 1'b0;
            base.message_done   = 1'b0;
        end
    end

    assign code    = seg_code(item.value);
    assign pos_inc = base.digit_position + 4'd1;
    assign flush   = (pos_inc >= 4'(DIGITS));
    assign level   = (item.value > {4'h0, MAX_LEVEL}) ? MAX_LEVEL : item.value[3:0];

    // Next state and frames for each mode.
    always_comb begin
        state_next = state_cur;
        burst      = '0;
        unique case (item.mode)
            MODE_CHAR: begin
                state_next = base;
                if (base.message_done) begin
                    // Characters after the last digit are dropped.
                end else if (item.value == CHAR_POINT && !base.dot_consumed) begin
                    state_next.dot_consumed = 1'b1;
                    if (base.held_valid) begin
                        state_next.held_code = base.held_code | POINT_BIT;
                    end
                end else begin
                    state_next.dot_consumed   = 1'b0;
                    state_next.held_code      = code;
                    state_next.held_valid     = !flush;
                    state_next.message_done   = flush;
                    state_next.digit_position = pos_inc;
                    if (base.held_valid) begin
                        burst.slot0_address = base.digit_position;
                        burst.slot0_data    = base.held_code;
                        burst.slot1_address = pos_inc;
                        burst.slot1_data    = code;
                        burst.count         = flush ? 3'd2 : 3'd1;
                    end else if (flush) begin
                        burst.slot0_address = pos_inc;
                        burst.slot0_data    = code;
                        burst.count         = 3'd1;
                    end
                end
            end
            MODE_BRIGHT: begin
                if (level != state_cur.last_brightness) begin
                    state_next.last_brightness = level;
                    burst.slot0_address        = ADDR_BRIGHT;
                    burst.slot0_data           = {4'h0, level};
                    burst.count                = 3'd1;
                end
            end
            MODE_INIT: begin
                state_next.digit_position = 4'd0;
                state_next.held_code      = 8'h00;
                state_next.held_valid     = 1'b0;
                state_next.dot_consumed   = 1'b0;
                state_next.message_done   = 1'b0;
                burst.init_seq            = 1'b1;
                burst.count               = INIT_COUNT;
            end
            MODE_NONE: begin
                // Reserved mode: no frames, no state change.
            end
        endcase
    end

endmodule

>>> tb/text_to_segment_frame_writer_test.sv
// ----------------------------------------------------------------------------
// text_to_segment_frame_writer_test: self-checking bench for the frame writer
// Sends characters, brightness and init requests over the input channel, and
// predicts every display driver frame with a behavioral copy of the writer.
// Each received frame is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module text_to_segment_frame_writer_test;
    import ttsf_pkg::*;

    localparam int DIGIT_COUNT    = 8;
    localparam int RANDOM_ITEMS   = 395;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int REPORT_LIMIT   = 10;

    // Data bytes of the driver setup sequence.
    localparam logic [7:0] TEST_OFF    = 8'h00;
    localparam logic [7:0] SCAN_ALL    = 8'h07;
    localparam logic [7:0] DECODE_NONE = 8'h00;
    localparam logic [7:0] BRIGHT_INIT = 8'h0A;
    localparam logic [7:0] POWER_ON    = 8'h01;
    localparam logic [7:0] BLANK_CODE  = 8'h00;

    // Segment pattern of each character code 0..128.
    localparam logic [7:0] SEG_MAP [0:128] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'hE5, 8'hE5, 8'hE5, 8'hE5, 8'hE5, 8'hE5, 8'hE5,
        8'hE5, 8'hE5, 8'hE5, 8'hE5, 8'hE5, 8'h01, 8'hE5, 8'hE5,
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
        8'h7F, 8'h7B, 8'hE5, 8'hE5, 8'hE5, 8'hE5, 8'hE5, 8'hE5,
        8'hE5, 8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47, 8'h5F,
        8'h37, 8'h30, 8'h3C, 8'h87, 8'h0E, 8'hE5, 8'h76, 8'h7E,
        8'h67, 8'hFE, 8'h66, 8'h5B, 8'h0F, 8'h3E, 8'h3E, 8'hE5,
        8'h37, 8'h33, 8'h6D, 8'hE5, 8'hE5, 8'hE5, 8'hE5, 8'hE5,
        8'hE5, 8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47, 8'h5F,
        8'h17, 8'h30, 8'h3C, 8'h87, 8'h0E, 8'hE5, 8'h15, 8'h1D,
        8'h67, 8'h73, 8'h05, 8'h5B, 8'h0F, 8'h1C, 8'h1C, 8'hD3,
        8'h37, 8'h33, 8'h6D, 8'hE5, 8'hE5, 8'hE5, 8'hE5, 8'hE5,
        8'h00
    };

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // Predicted message and brightness state.
    logic [3:0] digit_pos;
    logic [7:0] held_segs;
    logic       held_ok;
    logic       dot_taken;
    logic       msg_done;
    logic [3:0] bright_level;

    out_item_t frames_due[$];
    bit        no_idle;
    int        errors;
    int        items_sent;
    int        items_live;
    int        frames_seen;
    int        messages_done;
    int        quiet_cycles;

    text_to_segment_frame_writer #(
        .DIGITS(DIGIT_COUNT)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic note_error(input string msg);
        errors++;
        if (errors <= REPORT_LIMIT) begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic push_frame(input logic [3:0] addr, input logic [7:0] data);
        out_item_t f;
        f.frame_address = addr;
        f.frame_data    = data;
        f.last_of_run   = 1'b0;
        frames_due.push_back(f);
    endtask

    task automatic clear_message();
        digit_pos = '0;
        held_segs = '0;
        held_ok   = 1'b0;
        dot_taken = 1'b0;
        msg_done  = 1'b0;
    endtask

    // Work out the frames that one accepted item causes and queue them.
    task automatic predict_frames(input in_item_t it, output bit ignored);
        logic [7:0] code;
        logic [3:0] lvl;
        int         queued;
        ignored = 1'b0;
        queued  = frames_due.size();
        case (it.mode)
            MODE_CHAR: begin
                if (it.start_of_message) begin
                    clear_message();
                end
                if (msg_done) begin
                    ignored = 1'b1;
                end else if (it.value == CHAR_POINT && !dot_taken) begin
                    // A period marks the held digit, or nothing if none is held.
                    dot_taken = 1'b1;
                    if (held_ok) begin
                        held_segs = held_segs | POINT_BIT;
                    end
                end else begin
                    code      = (it.value <= 8'd128) ? SEG_MAP[it.value] : BLANK_CODE;
                    dot_taken = 1'b0;
                    if (held_ok) begin
                        push_frame(digit_pos, held_segs);
                    end
                    held_segs = code;
                    held_ok   = 1'b1;
                    digit_pos = digit_pos + 4'd1;
                    // The final digit goes out at once and closes the message.
                    if (digit_pos >= DIGIT_COUNT) begin
                        push_frame(digit_pos, held_segs);
                        held_ok  = 1'b0;
                        msg_done = 1'b1;
                        messages_done++;
                    end
                end
            end
            MODE_BRIGHT: begin
                lvl = (it.value > MAX_LEVEL) ? MAX_LEVEL : it.value[3:0];
                if (lvl != bright_level) begin
                    bright_level = lvl;
                    push_frame(ADDR_BRIGHT, {4'd0, lvl});
                end
            end
            MODE_INIT: begin
                push_frame(ADDR_TEST, TEST_OFF);
                push_frame(ADDR_SCAN, SCAN_ALL);
                push_frame(ADDR_DECODE, DECODE_NONE);
                push_frame(ADDR_BRIGHT, BRIGHT_INIT);
                push_frame(ADDR_POWER, POWER_ON);
                clear_message();
            end
            default: begin
                ignored = 1'b1;
            end
        endcase
        if (frames_due.size() > queued) begin
            frames_due[frames_due.size() - 1].last_of_run = 1'b1;
        end
    endtask

    function automatic in_item_t item_of(input logic [1:0] mode, input logic start,
                                         input logic [7:0] value);
        in_item_t it;
        it.mode             = mode;
        it.start_of_message = start;
        it.value            = value;
        return it;
    endfunction

    // Offer one item, hold it until the transaction completes, then predict.
    task automatic send_item(input in_item_t it);
        int gap;
        bit ignored;
        gap = 0;
        while (!no_idle && $urandom_range(0, 99) < 16) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predict_frames(it, ignored);
        items_sent++;
        if (!ignored) begin
            items_live++;
        end
    endtask

    task automatic test_init_sequence();
        send_item(item_of(MODE_INIT, 1'b0, 8'h00));
    endtask

    // Full message with a point, a doubled period, blank codes and extra input.
    task automatic test_digit_message();
        send_item(item_of(MODE_CHAR, 1'b1, "0"));
        send_item(item_of(MODE_CHAR, 1'b0, "1"));
        send_item(item_of(MODE_CHAR, 1'b0, CHAR_POINT));
        send_item(item_of(MODE_CHAR, 1'b0, CHAR_POINT));
        send_item(item_of(MODE_CHAR, 1'b0, 8'h00));
        send_item(item_of(MODE_CHAR, 1'b0, 8'h80));
        send_item(item_of(MODE_CHAR, 1'b0, 8'hFF));
        send_item(item_of(MODE_CHAR, 1'b0, "A"));
        send_item(item_of(MODE_CHAR, 1'b0, "z"));
        send_item(item_of(MODE_CHAR, 1'b0, "x"));
    endtask

    // Period with nothing held, then a restart that drops a held digit.
    task automatic test_message_restart();
        send_item(item_of(MODE_CHAR, 1'b1, CHAR_POINT));
        send_item(item_of(MODE_CHAR, 1'b0, "7"));
        send_item(item_of(MODE_CHAR, 1'b1, "8"));
    endtask

    // Unchanged levels send nothing; large levels clamp to the maximum.
    task automatic test_brightness();
        send_item(item_of(MODE_BRIGHT, 1'b0, 8'd0));
        send_item(item_of(MODE_BRIGHT, 1'b0, 8'd3));
        send_item(item_of(MODE_BRIGHT, 1'b0, 8'd3));
        send_item(item_of(MODE_BRIGHT, 1'b0, 8'd255));
        send_item(item_of(MODE_BRIGHT, 1'b0, 8'd16));
        send_item(item_of(MODE_BRIGHT, 1'b1, 8'd0));
    endtask

    // The unused mode does nothing; the start flag means nothing to init.
    task automatic test_ignored_inputs();
        send_item(item_of(MODE_NONE, 1'b1, 8'hFF));
        send_item(item_of(MODE_INIT, 1'b1, 8'hFF));
    endtask

    // Mostly well-formed messages with random content, mixed with other requests.
    task automatic test_random_traffic();
        int base;
        int pick;
        int len;
        int kind;
        logic [7:0] ch;
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            no_idle = (items_sent - base >= 150) && (items_sent - base < 250);
            pick    = $urandom_range(0, 99);
            if (pick < 70) begin
                len = $urandom_range(1, 11);
                for (int i = 0; i < len; i++) begin
                    kind = $urandom_range(0, 99);
                    if (kind < 25) begin
                        ch = CHAR_POINT;
                    end else if (kind < 80) begin
                        ch = 8'($urandom_range(8'h20, 8'h7E));
                    end else begin
                        ch = 8'($urandom_range(0, 255));
                    end
                    send_item(item_of(MODE_CHAR,
                                      (i == 0) && ($urandom_range(0, 9) != 0), ch));
                end
            end else if (pick < 82) begin
                ch = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 20))
                                                 : 8'($urandom_range(0, 255));
                send_item(item_of(MODE_BRIGHT, 1'($urandom_range(0, 1)), ch));
            end else if (pick < 87) begin
                send_item(item_of(MODE_INIT, 1'($urandom_range(0, 1)),
                                  8'($urandom_range(0, 255))));
            end else if (pick < 91) begin
                send_item(item_of(MODE_NONE, 1'($urandom_range(0, 1)),
                                  8'($urandom_range(0, 255))));
            end else begin
                len = $urandom_range(1, 4);
                repeat (len) begin
                    send_item(item_of(MODE_CHAR, 1'($urandom_range(0, 1)),
                                      8'($urandom_range(0, 255))));
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // Result side: random back-pressure outside the calm stretch.
    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(0, 99) >= 16);
    end

    // Compare each received frame with the oldest prediction.
    always @(posedge aclk) begin : check_frames
        out_item_t due;
        if (aresetn && m_valid && m_ready) begin
            frames_seen++;
            if (frames_due.size() == 0) begin
                note_error($sformatf("frame with none expected: addr %h data %h last %b",
                                     m_data.frame_address, m_data.frame_data,
                                     m_data.last_of_run));
            end else begin
                due = frames_due.pop_front();
                if (m_data.frame_address !== due.frame_address
                        || m_data.frame_data !== due.frame_data
                        || m_data.last_of_run !== due.last_of_run) begin
                    note_error($sformatf(
                        "frame %0d: expected addr %h data %h last %b, got %h %h %b",
                        frames_seen, due.frame_address, due.frame_data,
                        due.last_of_run, m_data.frame_address, m_data.frame_data,
                        m_data.last_of_run));
                end
            end
        end
    end

    // Stop a hung run: no transaction on either channel for too long.
    always @(posedge aclk) begin
        if (aresetn && !((s_valid && s_ready) || (m_valid && m_ready))) begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("text_to_segment_frame_writer_test: errors");
                $finish;
            end
        end else begin
            quiet_cycles = 0;
        end
    end

    initial begin
        clear_message();
        bright_level = '0;
        no_idle      = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_init_sequence();
        test_digit_message();
        test_message_restart();
        test_brightness();
        test_ignored_inputs();
        test_random_traffic();
        s_valid <= 1'b0;

        // Let the last frames drain, then watch for stray ones.
        while (frames_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (frames_due.size() != 0) begin
            note_error($sformatf("%0d frames never arrived", frames_due.size()));
        end

        $display("summary: %0d items sent, %0d of them acted on, %0d frames checked",
                 items_sent, items_live, frames_seen);
        $display("summary: %0d messages filled all digits, %0d errors",
                 messages_done, errors);
        if (errors == 0) begin
            $display("text_to_segment_frame_writer_test: clean");
        end else begin
            $display("text_to_segment_frame_writer_test: errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/ttsf_pkg.sv
design/ttsf_item_logic.sv
design/text_to_segment_frame_writer.sv
tb/text_to_segment_frame_writer_test.sv
